>>> hdl/rdq_pkg.sv
// Package for the RV32I decode queue: payload types, decode constants and sizes.
`timescale 1ns / 1ps
`default_nettype none
package rdq_pkg;

  // Ring size; the ring keeps one slot free, so it holds QUEUE_DEPTH-1 entries.
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int TAG_WIDTH   = 4;

  // Major opcodes of RV32I.
  localparam logic [6:0] OPC_REG    = 7'b0110011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;

  // funct3 / funct7 codes of the shift-immediate instructions.
  localparam logic [2:0] F3_SLLI  = 3'd1;
  localparam logic [2:0] F3_SRXI  = 3'd5;
  localparam logic [6:0] F7_BASE  = 7'b0000000;
  localparam logic [6:0] F7_ALT   = 7'b0100000;

  typedef enum logic [2:0] {
    FMT_R   = 3'd0,
    FMT_I   = 3'd1,
    FMT_SH  = 3'd2,
    FMT_S   = 3'd3,
    FMT_B   = 3'd4,
    FMT_J   = 3'd5,
    FMT_U   = 3'd6,
    FMT_BAD = 3'd7
  } fmt_t;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic                 squash;
    logic                 pop_head;
    logic                 in_valid;
    logic [31:0]          raw_word;
    logic [31:0]          fetch_pc;
    logic [31:0]          predicted_pc;
    logic [TAG_WIDTH-1:0] checkpoint_tag;
    logic                 halt_mark;
  } in_word_t;

  typedef struct packed {
    logic                 accepted;
    logic                 head_valid;
    logic                 head_halt;
    logic [2:0]           head_format;
    logic [16:0]          head_op_funct;
    logic [4:0]           head_dest;
    logic [4:0]           head_src1;
    logic [4:0]           head_src2;
    logic signed [31:0]   head_immediate;
    logic [31:0]          head_pc;
    logic [31:0]          head_predicted_pc;
    logic [TAG_WIDTH-1:0] head_checkpoint;
  } out_word_t;

  // One decoded queue entry.
  typedef struct packed {
    fmt_t                 fmt;
    logic [16:0]          op_funct;
    logic [4:0]           dest;
    logic [4:0]           src1;
    logic [4:0]           src2;
    logic signed [31:0]   imm;
    logic [31:0]          pc;
    logic [31:0]          pred;
    logic [TAG_WIDTH-1:0] tag;
    logic                 halt;
  } entry_t;

  // Ring control from the top level.
  typedef struct packed {
    logic step;
    logic squash;
    logic pop;
    logic push;
  } ring_ctl_t;

  // Ring status: empty and full as seen before the current step, and whether this step pushes.
  typedef struct packed {
    logic empty;
    logic full;
    logic pushed;
  } ring_stat_t;

endpackage
`default_nettype wire

>>> hdl/rv32i_decode_queue.sv
// Top level of the RV32I decode queue: input register, decode, ring and result register.
// An accepted word is held in the input register, then its result word in the result register.
// Throughput: one word per cycle while the result register has room (out_ready);
// each step decodes, pushes and pops together.
// Reset (rst_n low, synchronous) empties the ring and clears both channel valid flags.
// Queue slots are not cleared; their contents reach the result only after being written.
`timescale 1ns / 1ps
`default_nettype none
module rv32i_decode_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  rdq_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output rdq_pkg::out_word_t out_data
);
  import rdq_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  in_word_t   s1_data_r;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r, out_data_nxt;
  logic       step_go;
  entry_t     dec_entry;
  entry_t     head_entry;
  ring_ctl_t  ring_ctl;
  ring_stat_t ring_stat;

  // A step runs when an input word is held and the result register has room.
  assign step_go  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step_go;

  rdq_decode u_decode (
    .word_i  (s1_data_r),
    .entry_o (dec_entry)
  );

  assign ring_ctl.step   = step_go;
  assign ring_ctl.squash = s1_data_r.squash;
  assign ring_ctl.pop    = s1_data_r.pop_head;
  assign ring_ctl.push   = s1_data_r.in_valid;

  rdq_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ring_ctl),
    .entry_i (dec_entry),
    .head_o  (head_entry),
    .stat_o  (ring_stat)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (step_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // The result shows the head as it stood before the step, or zero head fields when empty.
  always_comb begin
    out_data_nxt                   = '0;
    out_data_nxt.accepted          = ring_stat.pushed;
    out_data_nxt.head_valid        = !ring_stat.empty;
    if (!ring_stat.empty) begin
      out_data_nxt.head_halt         = head_entry.halt;
      out_data_nxt.head_format       = head_entry.fmt;
      out_data_nxt.head_op_funct     = head_entry.op_funct;
      out_data_nxt.head_dest         = head_entry.dest;
      out_data_nxt.head_src1         = head_entry.src1;
      out_data_nxt.head_src2         = head_entry.src2;
      out_data_nxt.head_immediate    = head_entry.imm;
      out_data_nxt.head_pc           = head_entry.pc;
      out_data_nxt.head_predicted_pc = head_entry.pred;
      out_data_nxt.head_checkpoint   = head_entry.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (step_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The ring can never look empty and full at once.
  a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_stat.empty && ring_stat.full))
    else $error("ring reports empty and full together");

  // A squash step leaves the ring empty.
  a_squash_empties: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && s1_data_r.squash |=> ring_stat.empty)
    else $error("ring not empty after squash");

  // A push leaves at least one entry in the ring.
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    ring_stat.pushed |=> !ring_stat.empty)
    else $error("ring empty right after a push");

  // The accept flag of a result matches the push made by its step.
  a_accept_flag: assert property (@(posedge clk) disable iff (!rst_n)
    step_go |=> out_valid_r && (out_data_r.accepted == $past(ring_stat.pushed)))
    else $error("accept flag differs from the push of its step");

endmodule
`default_nettype wire

>>> hdl/rdq_decode.sv
// Combinational RV32I field and immediate decoder for one queue entry.
`timescale 1ns / 1ps
`default_nettype none
module rdq_decode (
  input  rdq_pkg::in_word_t word_i,
  output rdq_pkg::entry_t   entry_o
);
  import rdq_pkg::*;

  logic [31:0] w;
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7_raw;
  logic [6:0]  f7;
  fmt_t        fmt;
  logic [31:0] imm;
  logic        is_shift;

  assign w      = word_i.raw_word;
  assign op     = w[6:0];
  assign f3     = w[14:12];
  assign f7_raw = w[31:25];

  assign is_shift = ((f3 == F3_SLLI) && (f7_raw == F7_BASE)) ||
                    ((f3 == F3_SRXI) && ((f7_raw == F7_BASE) || (f7_raw == F7_ALT)));

  always_comb begin
    f7  = '0;
    imm = '0;
    fmt = FMT_BAD;
    unique case (op)
      OPC_REG: begin
        fmt = FMT_R;
        f7  = f7_raw;
      end
      OPC_IMM: begin
        f7 = f7_raw;
        if (is_shift) begin
          fmt = FMT_SH;
          imm = {27'd0, w[24:20]};
        end else begin
          fmt = FMT_I;
          imm = {{20{w[31]}}, w[31:20]};
        end
      end
      OPC_LOAD, OPC_JALR: begin
        fmt = FMT_I;
        imm = {{20{w[31]}}, w[31:20]};
      end
      OPC_STORE: begin
        fmt = FMT_S;
        imm = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      OPC_BRANCH: begin
        fmt = FMT_B;
        imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      end
      OPC_JAL: begin
        fmt = FMT_J;
        imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OPC_AUIPC, OPC_LUI: begin
        fmt = FMT_U;
        imm = {w[31:12], 12'd0};
      end
      default: begin
        fmt = FMT_BAD;
      end
    endcase
  end

  always_comb begin
    entry_o.fmt      = fmt;
    entry_o.op_funct = {f7, f3, op};
    entry_o.dest     = w[11:7];
    entry_o.src1     = w[19:15];
    entry_o.src2     = w[24:20];
    entry_o.imm      = imm;
    entry_o.pc       = word_i.fetch_pc;
    entry_o.pred     = word_i.predicted_pc;
    entry_o.tag      = word_i.checkpoint_tag;
    entry_o.halt     = word_i.halt_mark;
  end

endmodule
`default_nettype wire

>>> hdl/rdq_ring.sv
// Ring queue of decoded entries with head and tail pointers and one spare slot.
`timescale 1ns / 1ps
`default_nettype none
module rdq_ring (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rdq_pkg::ring_ctl_t   ctl_i,
  input  rdq_pkg::entry_t      entry_i,
  output rdq_pkg::entry_t      head_o,
  output rdq_pkg::ring_stat_t  stat_o
);
  import rdq_pkg::*;

  ptr_t   head_r, head_nxt;
  ptr_t   tail_r, tail_nxt;
  entry_t slot_r [QUEUE_DEPTH];
  entry_t head_ent_r;
  logic   empty;
  logic   full;
  logic   do_push;

  function automatic ptr_t advance(input ptr_t p);
    advance = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  assign empty   = (head_r == tail_r);
  assign full    = (advance(tail_r) == head_r);
  // Room is judged on the state before this step; a pop in the same step frees none.
  assign do_push = ctl_i.step && !ctl_i.squash && ctl_i.push && !full;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl_i.step) begin
      if (ctl_i.squash) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else begin
        if (ctl_i.pop && !empty) begin
          head_nxt = advance(head_r);
        end
        if (do_push) begin
          tail_nxt = advance(tail_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[tail_r] <= entry_i;
    end
    // The head entry is registered from the slot at the next head position; a push that lands on the new head
    // position goes straight through.
    if (do_push && (tail_r == head_nxt)) begin
      head_ent_r <= entry_i;
    end else begin
      head_ent_r <= slot_r[head_nxt];
    end
  end

  assign head_o        = head_ent_r;
  assign stat_o.empty  = empty;
  assign stat_o.full   = full;
  assign stat_o.pushed = do_push;

endmodule
`default_nettype wire
